/* hw/rtl/swcc_pkg.sv */
// Shared types and constants for the segment wall collision check block.
package swcc_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned MaxEdges  = 64;
  localparam int unsigned IdxBits   = $clog2(MaxEdges);
  localparam int unsigned CntBits   = $clog2(MaxEdges + 1);
  localparam int unsigned DifBits   = CoordBits + 1;
  localparam int unsigned DetBits   = 2 * CoordBits + 1;
  localparam int unsigned DenBits   = 2 * DifBits + 1;
  localparam int unsigned WideBits  = DetBits + DifBits + 2;
  localparam int unsigned PipeLat   = 7;
  localparam int unsigned WaitBits  = $clog2(PipeLat + 1);

  localparam logic OpAdd   = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t by;
    coord_t bx;
    coord_t ay;
    coord_t ax;
  } edge_t;

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic idx_inc;
    logic wr_en;
    logic res_we;
    logic res_clear;
    logic res_full;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic fits;
    logic empty;
    logic idx_last;
    logic quad_done;
    logic blocked;
  } sts_t;

endpackage

/* hw/rtl/swcc_datapath.sv */
// Datapath: input hold, edge memory, exact intersection pipeline and result register.
module swcc_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  swcc_pkg::cmd_t                    cmd_i,
  output swcc_pkg::sts_t                    sts_o,
  input  logic                              op_i,
  input  swcc_pkg::coord_t [3:0]            px_i,
  input  swcc_pkg::coord_t [3:0]            py_i,
  output logic                              path_clear_o,
  output logic                              table_full_o
);

  localparam int unsigned W = swcc_pkg::WideBits;

  logic                           op_q;
  swcc_pkg::coord_t [3:0]         x_q, y_q;
  logic [swcc_pkg::CntBits-1:0]   count_q;
  logic [swcc_pkg::CntBits-1:0]   idx_q;
  swcc_pkg::edge_t                mem_q [swcc_pkg::MaxEdges];
  swcc_pkg::edge_t                rd_q;
  swcc_pkg::edge_t                wr_edge;
  logic [1:0]                     k, k1;

  logic signed [2*swcc_pkg::CoordBits-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [swcc_pkg::DifBits-1:0]     dx1_q, dy1_q, dx2_q, dy2_q;
  logic signed [swcc_pkg::DetBits-1:0]     det1_q, det2_q;
  logic signed [swcc_pkg::DenBits-1:0]     dna_q, dnb_q, den_q, den_p_q;
  logic signed [W-1:0]                     m1_q, m2_q, m3_q, m4_q, xn_q, yn_q;
  logic signed [W-1:0]                     b_q [8];
  logic                                    zero_q, blk_q;
  logic                                    path_clear_q, table_full_q;

  swcc_pkg::coord_t bnd [8];
  logic signed [W-1:0] xn_d, yn_d;

  function automatic logic signed [swcc_pkg::DifBits-1:0] DifBitsExt(swcc_pkg::coord_t v);
    return swcc_pkg::DifBits'(v);
  endfunction

  assign k  = idx_q[1:0];
  assign k1 = k + 2'd1;
  assign wr_edge = '{by: y_q[k1], bx: x_q[k1], ay: y_q[k], ax: x_q[k]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      idx_q        <= '0;
      path_clear_q <= 1'b0;
      table_full_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) count_q <= count_q + 1'b1;
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.res_we) begin
        path_clear_q <= cmd_i.res_clear;
        table_full_q <= cmd_i.res_full;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      x_q  <= px_i;
      y_q  <= py_i;
    end
    if (cmd_i.wr_en) mem_q[count_q[swcc_pkg::IdxBits-1:0]] <= wr_edge;
    rd_q <= mem_q[idx_q[swcc_pkg::IdxBits-1:0]];
  end

  // Stage 1: corner products and differences
  always_ff @(posedge clk_i) begin
    pa_q  <= rd_q.ax * rd_q.by;
    pb_q  <= rd_q.ay * rd_q.bx;
    pc_q  <= x_q[0] * y_q[1];
    pd_q  <= y_q[0] * x_q[1];
    dx1_q <= DifBitsExt(rd_q.ax) - DifBitsExt(rd_q.bx);
    dy1_q <= DifBitsExt(rd_q.ay) - DifBitsExt(rd_q.by);
    dx2_q <= DifBitsExt(x_q[0]) - DifBitsExt(x_q[1]);
    dy2_q <= DifBitsExt(y_q[0]) - DifBitsExt(y_q[1]);
  end

  // Stage 2: determinants and denominator products
  always_ff @(posedge clk_i) begin
    det1_q <= swcc_pkg::DetBits'(pa_q) - swcc_pkg::DetBits'(pb_q);
    det2_q <= swcc_pkg::DetBits'(pc_q) - swcc_pkg::DetBits'(pd_q);
    dna_q  <= swcc_pkg::DenBits'(dx1_q) * swcc_pkg::DenBits'(dy2_q);
    dnb_q  <= swcc_pkg::DenBits'(dy1_q) * swcc_pkg::DenBits'(dx2_q);
  end

  // Stage 3: denominator and numerator products
  always_ff @(posedge clk_i) begin
    den_q <= dna_q - dnb_q;
    m1_q  <= W'(det1_q) * W'(dx2_q);
    m2_q  <= W'(dx1_q) * W'(det2_q);
    m3_q  <= W'(det1_q) * W'(dy2_q);
    m4_q  <= W'(dy1_q) * W'(det2_q);
  end

  // Stage 4: numerators, signs flipped so that the denominator is positive
  assign xn_d = m1_q - m2_q;
  assign yn_d = m3_q - m4_q;

  always_ff @(posedge clk_i) begin
    zero_q <= (den_q == '0);
    if (den_q[swcc_pkg::DenBits-1]) begin
      xn_q    <= -xn_d;
      yn_q    <= -yn_d;
      den_p_q <= -den_q;
    end else begin
      xn_q    <= xn_d;
      yn_q    <= yn_d;
      den_p_q <= den_q;
    end
  end

  // Stage 5: bounds scaled by the denominator
  always_comb begin
    bnd[0] = (rd_q.ax < rd_q.bx) ? rd_q.ax : rd_q.bx;
    bnd[1] = (rd_q.ax < rd_q.bx) ? rd_q.bx : rd_q.ax;
    bnd[2] = (rd_q.ay < rd_q.by) ? rd_q.ay : rd_q.by;
    bnd[3] = (rd_q.ay < rd_q.by) ? rd_q.by : rd_q.ay;
    bnd[4] = (x_q[0] < x_q[1]) ? x_q[0] : x_q[1];
    bnd[5] = (x_q[0] < x_q[1]) ? x_q[1] : x_q[0];
    bnd[6] = (y_q[0] < y_q[1]) ? y_q[0] : y_q[1];
    bnd[7] = (y_q[0] < y_q[1]) ? y_q[1] : y_q[0];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) begin
      b_q[i] <= W'(bnd[i]) * W'(den_p_q);
    end
  end

  // Stage 6: range compares
  always_ff @(posedge clk_i) begin
    blk_q <= zero_q ||
             ((xn_q >= b_q[0]) && (b_q[1] >= xn_q) &&
              (yn_q >= b_q[2]) && (b_q[3] >= yn_q) &&
              (xn_q >= b_q[4]) && (b_q[5] >= xn_q) &&
              (yn_q >= b_q[6]) && (b_q[7] >= yn_q));
  end

  assign sts_o.is_query  = op_q;
  assign sts_o.fits      = (count_q <= swcc_pkg::CntBits'(swcc_pkg::MaxEdges - 4));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.idx_last  = (idx_q + 1'b1 == count_q);
  assign sts_o.quad_done = (k == 2'd3);
  assign sts_o.blocked   = blk_q;

  assign path_clear_o = path_clear_q;
  assign table_full_o = table_full_q;

endmodule

/* hw/rtl/swcc_ctrl.sv */
// Controller: sequences add writes, the edge scan and the result handshake.
module swcc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output swcc_pkg::cmd_t cmd_o,
  input  swcc_pkg::sts_t sts_i
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StAdd  = 4'b0010,
    StScan = 4'b0100,
    StResp = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  logic [swcc_pkg::WaitBits-1:0] wait_q, wait_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      wait_q  <= '0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
    end
  end

  always_comb begin
    state_d = state_q;
    wait_d  = wait_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.idx_clr = 1'b1;
          wait_d        = '0;
          state_d       = StScan;
        end
      end
      StScan: begin
        if (!sts_i.is_query) begin
          if (sts_i.fits) begin
            state_d = StAdd;
          end else begin
            cmd_o.res_we   = 1'b1;
            cmd_o.res_full = 1'b1;
            state_d        = StResp;
          end
        end else if (sts_i.empty) begin
          cmd_o.res_we    = 1'b1;
          cmd_o.res_clear = 1'b1;
          state_d         = StResp;
        end else if (wait_q == swcc_pkg::WaitBits'(swcc_pkg::PipeLat)) begin
          if (sts_i.blocked) begin
            cmd_o.res_we = 1'b1;
            state_d      = StResp;
          end else if (sts_i.idx_last) begin
            cmd_o.res_we    = 1'b1;
            cmd_o.res_clear = 1'b1;
            state_d         = StResp;
          end else begin
            cmd_o.idx_inc = 1'b1;
            wait_d        = '0;
          end
        end else begin
          wait_d = wait_q + 1'b1;
        end
      end
      StAdd: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.quad_done) begin
          cmd_o.res_we = 1'b1;
          state_d      = StResp;
        end
      end
      StResp: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StResp);

endmodule

/* hw/rtl/segment_wall_collision_check_top.sv */
// Top level of the segment wall collision check block.
// Slave stream: tuser carries operation (0 adds a quadrilateral wall, 1 queries
// a segment); tdata carries the four corners, x then y, first corner lowest.
// An add stores the four closed edges of the quadrilateral, or, when fewer than
// four of the 64 slots are free, stores nothing and returns table_full = 1.
// A query returns path_clear = 1 when no stored edge blocks the segment.
// Each item yields exactly one result item on the master stream.
// An add writes its edges in turn before tvalid rises; a rejected add or
// a query on an empty table is answered directly from the scan state; a query
// checks the stored edges one at a time (up to all stored edges; the scan stops
// at the first blocking edge). Each edge goes through a 7-stage multiply and
// compare pipeline reading one memory entry before the controller decides on it.
// One item is in flight at a time; tready drops from accept until the result
// has been taken. A stalled receiver holds the result and the input side.
// Reset empties the edge table; its contents need no clearing.
module segment_wall_collision_check_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // first_x, first_y, second_x, second_y,
                                      // third_x, third_y, fourth_x, fourth_y
  input  logic         s_axis_tuser,  // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata   // path_clear, table_full, zero fill
);

  swcc_pkg::cmd_t           cmd;
  swcc_pkg::sts_t           sts;
  swcc_pkg::coord_t [3:0]   px, py;
  logic                     path_clear, table_full;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      px[i] = s_axis_tdata[32*i +: 16];
      py[i] = s_axis_tdata[32*i + 16 +: 16];
    end
  end

  swcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  swcc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (s_axis_tuser),
    .px_i         (px),
    .py_i         (py),
    .path_clear_o (path_clear),
    .table_full_o (table_full)
  );

  assign m_axis_tdata = {6'b0, table_full, path_clear};

endmodule
